// ===== hw/rtl/weighted_centroid_with_spread_defines.svh =====
// ---------------------------------------------------------------------------
// weighted_centroid_with_spread_defines
// Assertion macros used by the checker file.
// ---------------------------------------------------------------------------
`ifndef WEIGHTED_CENTROID_WITH_SPREAD_DEFINES_SVH
`define WEIGHTED_CENTROID_WITH_SPREAD_DEFINES_SVH

// same-cycle implication, disabled in reset
`define WCS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define WCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/wcs_pkg.sv =====
// ---------------------------------------------------------------------------
// wcs_pkg
// Fixed output widths and saturation limits.
// ---------------------------------------------------------------------------
package wcs_pkg;
    localparam int OUT_BITS   = 16;
    localparam int CEN_MAX    = 32767;
    localparam int CEN_MIN    = -32768;
    localparam int SPREAD_MAX = 65535;
endpackage

// ===== hw/rtl/wcs_div_cell.sv =====
// ---------------------------------------------------------------------------
// wcs_div_cell
// One restoring division step: decides quotient bit I.
// ---------------------------------------------------------------------------
module wcs_div_cell #(
    parameter int RW = 8,
    parameter int DW = 4,
    parameter int QW = 4,
    parameter int TW = 1,
    parameter int I  = 0
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [RW-1:0] in_rem,
    input  logic [DW-1:0] in_den,
    input  logic [QW-1:0] in_quo,
    input  logic [TW-1:0] in_tag,
    output logic          out_valid,
    output logic [RW-1:0] out_rem,
    output logic [DW-1:0] out_den,
    output logic [QW-1:0] out_quo,
    output logic [TW-1:0] out_tag
);
    logic [RW+QW-1:0] dsh;
    logic [RW+QW-1:0] rem_x;
    logic             take;
    logic [RW-1:0]    rem_next;
    logic [QW-1:0]    quo_next;
    logic             valid_reg;
    logic [RW-1:0]    rem_reg;
    logic [DW-1:0]    den_reg;
    logic [QW-1:0]    quo_reg;
    logic [TW-1:0]    tag_reg;

    always_comb begin
        dsh      = {{(RW+QW-DW){1'b0}}, in_den} << I;
        rem_x    = {{QW{1'b0}}, in_rem};
        take     = (rem_x >= dsh);
        rem_next = take ? RW'(rem_x - dsh) : in_rem;
        quo_next = in_quo;
        quo_next[I] = take;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            den_reg <= in_den;
            quo_reg <= quo_next;
            tag_reg <= in_tag;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_quo   = quo_reg;
    assign out_tag   = tag_reg;
endmodule

// ===== hw/rtl/wcs_sqrt_cell.sv =====
// ---------------------------------------------------------------------------
// wcs_sqrt_cell
// One digit-by-digit square root step: decides root bit I.
// ---------------------------------------------------------------------------
module wcs_sqrt_cell #(
    parameter int VW = 8,
    parameter int TW = 1,
    parameter int I  = 0
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [VW-1:0] in_rem,
    input  logic [VW-1:0] in_res,
    input  logic [TW-1:0] in_tag,
    output logic          out_valid,
    output logic [VW-1:0] out_rem,
    output logic [VW-1:0] out_res,
    output logic [TW-1:0] out_tag
);
    logic [VW-1:0] bitv;
    logic [VW:0]   trial;
    logic          take;
    logic [VW-1:0] rem_next;
    logic [VW-1:0] res_next;
    logic          valid_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] res_reg;
    logic [TW-1:0] tag_reg;

    always_comb begin
        bitv     = VW'(1) << (2 * I);
        trial    = {1'b0, in_res} + {1'b0, bitv};
        take     = ({1'b0, in_rem} >= trial);
        rem_next = take ? VW'({1'b0, in_rem} - trial) : in_rem;
        res_next = take ? ((in_res >> 1) + bitv) : (in_res >> 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            res_reg <= res_next;
            tag_reg <= in_tag;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_res   = res_reg;
    assign out_tag   = tag_reg;
endmodule

// ===== hw/rtl/weighted_centroid_with_spread.sv =====
// Stages in order: A, B, divider one, C to G, divider two, root, output register.
// Throughput: one word per cycle while the skid word is empty; the row of divide and root cells is the pipeline.
// Output stalls fill a one-word skid register, then s_ready drops until it drains.
// Reset (aresetn low, synchronous) clears all valid flags; the datapath is not reset.
// ---------------------------------------------------------------------------
// weighted_centroid_with_spread
// Charge-weighted centroid and RMS spread of a three-pad cluster.
// ---------------------------------------------------------------------------
module weighted_centroid_with_spread
    import wcs_pkg::*;
#(
    parameter int POS_BITS    = 16,
    parameter int CHARGE_BITS = 20
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [POS_BITS-1:0]    s_pos_a,
    input  logic signed [POS_BITS-1:0]    s_pos_b,
    input  logic signed [POS_BITS-1:0]    s_pos_c,
    input  logic [CHARGE_BITS-1:0]        s_charge_a,
    input  logic [CHARGE_BITS-1:0]        s_charge_b,
    input  logic [CHARGE_BITS-1:0]        s_charge_c,
    input  logic                          s_present_a,
    input  logic                          s_present_b,
    input  logic                          s_present_c,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [OUT_BITS-1:0]    m_centroid,
    output logic [OUT_BITS-1:0]           m_spread,
    output logic                          m_no_weight
);
    localparam int P    = POS_BITS;
    localparam int C    = CHARGE_BITS;
    localparam int WS   = P + C + 2;      // signed weighted sum
    localparam int NW1  = P + C + 1;      // magnitude of weighted sum
    localparam int DW   = C + 2;          // total charge
    localparam int SW   = 2 * P;          // mean squared deviation
    localparam int TMW  = 2 * P + C;      // one pad's q*d^2
    localparam int VW   = 2 * P + C + 2;  // sum of q*d^2
    // first chain tag layout
    localparam int T_POS  = 0;
    localparam int T_CHG  = 3 * P;
    localparam int T_HERE = 3 * P + 3 * C;
    localparam int T_TOT  = T_HERE + 3;
    localparam int T_NEG  = T_TOT + DW;
    localparam int TW1    = T_NEG + 1;
    localparam int TW2    = P + 1;        // {no_weight, centroid}
    localparam int RES    = 2 * OUT_BITS + 1;

    // global advance: held only when the skid word is occupied
    logic en;
    logic accept;

    // stage A: masked products
    logic                  a_valid_reg;
    logic signed [P-1:0]   a_pos_reg  [3];
    logic [C-1:0]          a_chg_reg  [3];
    logic                  a_here_reg [3];
    logic signed [P+C:0]   a_prod_reg [3];
    logic signed [P-1:0]   in_pos  [3];
    logic [C-1:0]          in_chg  [3];
    logic                  in_here [3];

    // stage B: sums, feeds divider one
    logic                  b_valid_reg;
    logic [NW1-1:0]        b_mag_reg;
    logic [TW1-1:0]        b_tag_reg;
    logic signed [WS-1:0]  wsum;
    logic [DW-1:0]         total;

    // divider one chain (centroid)
    logic                  d1_valid [P+1];
    logic [NW1-1:0]        d1_rem   [P+1];
    logic [DW-1:0]         d1_den   [P+1];
    logic [P-1:0]          d1_quo   [P+1];
    logic [TW1-1:0]        d1_tag   [P+1];

    // stage C: deviations
    logic                  c_valid_reg;
    logic [P-1:0]          c_ad_reg   [3];
    logic [C-1:0]          c_chg_reg  [3];
    logic                  c_here_reg [3];
    logic [DW-1:0]         c_tot_reg;
    logic signed [P-1:0]   c_cen_reg;
    logic                  c_nw_reg;
    logic signed [P-1:0]   cen_calc;
    logic [P-1:0]          ad_calc [3];

    // stage D: squares
    logic                  dd_valid_reg;
    logic [SW-1:0]         dd_sq_reg   [3];
    logic [C-1:0]          dd_chg_reg  [3];
    logic                  dd_here_reg [3];
    logic [DW-1:0]         dd_tot_reg;
    logic [TW2-1:0]        dd_tag_reg;

    // stage E: split partial products
    logic                  e_valid_reg;
    logic [P+C-1:0]        e_lo_reg [3];
    logic [P+C-1:0]        e_hi_reg [3];
    logic [DW-1:0]         e_tot_reg;
    logic [TW2-1:0]        e_tag_reg;

    // stage F: per-pad terms
    logic                  f_valid_reg;
    logic [TMW-1:0]        f_term_reg [3];
    logic [DW-1:0]         f_tot_reg;
    logic [TW2-1:0]        f_tag_reg;

    // stage G: summed numerator
    logic                  g_valid_reg;
    logic [VW-1:0]         g_sum_reg;
    logic [DW-1:0]         g_tot_reg;
    logic [TW2-1:0]        g_tag_reg;

    // divider two chain (mean squared deviation)
    logic                  d2_valid [SW+1];
    logic [VW-1:0]         d2_rem   [SW+1];
    logic [DW-1:0]         d2_den   [SW+1];
    logic [SW-1:0]         d2_quo   [SW+1];
    logic [TW2-1:0]        d2_tag   [SW+1];

    // root chain
    logic                  r_valid [P+1];
    logic [SW-1:0]         r_rem   [P+1];
    logic [SW-1:0]         r_res   [P+1];
    logic [TW2-1:0]        r_tag   [P+1];

    // output side
    logic [RES-1:0]        res_word;
    logic                  push;
    logic                  pop;
    logic                  out_valid_reg;
    logic [RES-1:0]        out_word_reg;
    logic                  skid_valid_reg;
    logic [RES-1:0]        skid_word_reg;

    assign en      = !skid_valid_reg;
    assign s_ready = en;
    assign accept  = s_valid && en;

    assign in_pos[0]  = s_pos_a;
    assign in_pos[1]  = s_pos_b;
    assign in_pos[2]  = s_pos_c;
    assign in_chg[0]  = s_charge_a;
    assign in_chg[1]  = s_charge_b;
    assign in_chg[2]  = s_charge_c;
    assign in_here[0] = s_present_a;
    assign in_here[1] = s_present_b;
    assign in_here[2] = s_present_c;

    // ---- stage A: q*z per pad, absent pads contribute nothing ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= accept;
        end
    end

    // both factors widened to the product width before the multiply
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                a_pos_reg[i]  <= in_pos[i];
                a_chg_reg[i]  <= in_chg[i];
                a_here_reg[i] <= in_here[i];
                a_prod_reg[i] <= in_here[i]
                    ? ($signed({{(C+1){in_pos[i][P-1]}}, in_pos[i]})
                       * $signed({{P{1'b0}}, in_chg[i]}))
                    : '0;
            end
        end
    end

    // ---- stage B: weighted sum and total, sign split off for the divider ----
    always_comb begin
        wsum  = WS'(a_prod_reg[0]) + WS'(a_prod_reg[1]) + WS'(a_prod_reg[2]);
        total = (a_here_reg[0] ? DW'(a_chg_reg[0]) : '0)
              + (a_here_reg[1] ? DW'(a_chg_reg[1]) : '0)
              + (a_here_reg[2] ? DW'(a_chg_reg[2]) : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_mag_reg <= NW1'((wsum < 0) ? -wsum : wsum);
            b_tag_reg <= {(wsum < 0), total,
                          a_here_reg[2], a_here_reg[1], a_here_reg[0],
                          a_chg_reg[2], a_chg_reg[1], a_chg_reg[0],
                          a_pos_reg[2], a_pos_reg[1], a_pos_reg[0]};
        end
    end

    // ---- divider one: P cells, one quotient bit each, MSB first ----
    assign d1_valid[0] = b_valid_reg;
    assign d1_rem[0]   = b_mag_reg;
    assign d1_den[0]   = b_tag_reg[T_TOT +: DW];
    assign d1_quo[0]   = '0;
    assign d1_tag[0]   = b_tag_reg;

    for (genvar k = 0; k < P; k++) begin : g_div1
        wcs_div_cell #(
            .RW(NW1), .DW(DW), .QW(P), .TW(TW1), .I(P - 1 - k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (d1_valid[k]),
            .in_rem    (d1_rem[k]),
            .in_den    (d1_den[k]),
            .in_quo    (d1_quo[k]),
            .in_tag    (d1_tag[k]),
            .out_valid (d1_valid[k+1]),
            .out_rem   (d1_rem[k+1]),
            .out_den   (d1_den[k+1]),
            .out_quo   (d1_quo[k+1]),
            .out_tag   (d1_tag[k+1])
        );
    end

    // ---- stage C: signed centroid (truncated toward zero), |z - centroid| ----
    always_comb begin
        logic signed [P:0] dv;
        cen_calc = d1_tag[P][T_NEG] ? -$signed(d1_quo[P]) : $signed(d1_quo[P]);
        for (int i = 0; i < 3; i++) begin
            dv = (P+1)'($signed(d1_tag[P][T_POS + i*P +: P])) - (P+1)'(cen_calc);
            ad_calc[i] = P'((dv < 0) ? -dv : dv);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (en) begin
            c_valid_reg <= d1_valid[P];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                c_ad_reg[i]   <= ad_calc[i];
                c_chg_reg[i]  <= d1_tag[P][T_CHG + i*C +: C];
                c_here_reg[i] <= d1_tag[P][T_HERE + i];
            end
            c_tot_reg <= d1_tag[P][T_TOT +: DW];
            c_cen_reg <= cen_calc;
            c_nw_reg  <= (d1_tag[P][T_TOT +: DW] == '0);
        end
    end

    // ---- stage D: d^2 ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dd_valid_reg <= 1'b0;
        end else if (en) begin
            dd_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                dd_sq_reg[i]   <= SW'(c_ad_reg[i] * c_ad_reg[i]);
                dd_chg_reg[i]  <= c_chg_reg[i];
                dd_here_reg[i] <= c_here_reg[i];
            end
            dd_tot_reg <= c_tot_reg;
            dd_tag_reg <= {c_nw_reg, c_cen_reg};
        end
    end

    // ---- stage E: q*d^2 as two half-width partial products ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (en) begin
            e_valid_reg <= dd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                e_lo_reg[i] <= dd_here_reg[i]
                             ? (P+C)'(dd_sq_reg[i][P-1:0] * dd_chg_reg[i]) : '0;
                e_hi_reg[i] <= dd_here_reg[i]
                             ? (P+C)'(dd_sq_reg[i][SW-1:P] * dd_chg_reg[i]) : '0;
            end
            e_tot_reg <= dd_tot_reg;
            e_tag_reg <= dd_tag_reg;
        end
    end

    // ---- stage F: recombine halves ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (en) begin
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                f_term_reg[i] <= (TMW'(e_hi_reg[i]) << P) + TMW'(e_lo_reg[i]);
            end
            f_tot_reg <= e_tot_reg;
            f_tag_reg <= e_tag_reg;
        end
    end

    // ---- stage G: sum over pads ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_valid_reg <= 1'b0;
        end else if (en) begin
            g_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            g_sum_reg <= VW'(f_term_reg[0]) + VW'(f_term_reg[1]) + VW'(f_term_reg[2]);
            g_tot_reg <= f_tot_reg;
            g_tag_reg <= f_tag_reg;
        end
    end

    // ---- divider two: 2*P cells ----
    assign d2_valid[0] = g_valid_reg;
    assign d2_rem[0]   = g_sum_reg;
    assign d2_den[0]   = g_tot_reg;
    assign d2_quo[0]   = '0;
    assign d2_tag[0]   = g_tag_reg;

    for (genvar k = 0; k < SW; k++) begin : g_div2
        wcs_div_cell #(
            .RW(VW), .DW(DW), .QW(SW), .TW(TW2), .I(SW - 1 - k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (d2_valid[k]),
            .in_rem    (d2_rem[k]),
            .in_den    (d2_den[k]),
            .in_quo    (d2_quo[k]),
            .in_tag    (d2_tag[k]),
            .out_valid (d2_valid[k+1]),
            .out_rem   (d2_rem[k+1]),
            .out_den   (d2_den[k+1]),
            .out_quo   (d2_quo[k+1]),
            .out_tag   (d2_tag[k+1])
        );
    end

    // ---- root: P cells, one root bit each ----
    assign r_valid[0] = d2_valid[SW];
    assign r_rem[0]   = d2_quo[SW];
    assign r_res[0]   = '0;
    assign r_tag[0]   = d2_tag[SW];

    for (genvar k = 0; k < P; k++) begin : g_root
        wcs_sqrt_cell #(
            .VW(SW), .TW(TW2), .I(P - 1 - k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (r_valid[k]),
            .in_rem    (r_rem[k]),
            .in_res    (r_res[k]),
            .in_tag    (r_tag[k]),
            .out_valid (r_valid[k+1]),
            .out_rem   (r_rem[k+1]),
            .out_res   (r_res[k+1]),
            .out_tag   (r_tag[k+1])
        );
    end

    // ---- saturate to 16 bits, zero weight forces zero results ----
    always_comb begin
        logic signed [31:0] cen32;
        logic [31:0]        root32;
        logic [OUT_BITS-1:0] cen_o;
        logic [OUT_BITS-1:0] spr_o;
        cen32  = 32'(r_tag[P][P-1:0]);
        cen32  = 32'($signed(r_tag[P][P-1:0]));
        root32 = 32'(r_res[P][P-1:0]);
        if (cen32 > CEN_MAX) begin
            cen_o = OUT_BITS'(CEN_MAX);
        end else if (cen32 < CEN_MIN) begin
            cen_o = OUT_BITS'(CEN_MIN);
        end else begin
            cen_o = cen32[OUT_BITS-1:0];
        end
        spr_o = (root32 > 32'(SPREAD_MAX)) ? OUT_BITS'(SPREAD_MAX) : root32[OUT_BITS-1:0];
        if (r_tag[P][P]) begin
            res_word = {1'b1, {OUT_BITS{1'b0}}, {OUT_BITS{1'b0}}};
        end else begin
            res_word = {1'b0, spr_o, cen_o};
        end
    end

    // ---- output word plus one skid word ----
    assign push = r_valid[P] && en;
    assign pop  = out_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || pop) begin
            out_word_reg <= skid_valid_reg ? skid_word_reg : res_word;
        end
        if (push && out_valid_reg && !pop) begin
            skid_word_reg <= res_word;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_centroid  = $signed(out_word_reg[OUT_BITS-1:0]);
    assign m_spread    = out_word_reg[2*OUT_BITS-1:OUT_BITS];
    assign m_no_weight = out_word_reg[2*OUT_BITS];
endmodule

// ===== hw/rtl/wcs_checker.sv =====
// ---------------------------------------------------------------------------
// wcs_checker
// Port-level checks on the centroid/spread block, bound to the top level.
// ---------------------------------------------------------------------------
`include "weighted_centroid_with_spread_defines.svh"

module wcs_checker
    import wcs_pkg::*;
#(
    parameter int POS_BITS    = 16,
    parameter int CHARGE_BITS = 20
) (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic signed [POS_BITS-1:0] s_pos_a,
    input logic signed [POS_BITS-1:0] s_pos_b,
    input logic signed [POS_BITS-1:0] s_pos_c,
    input logic [CHARGE_BITS-1:0]     s_charge_a,
    input logic [CHARGE_BITS-1:0]     s_charge_b,
    input logic [CHARGE_BITS-1:0]     s_charge_c,
    input logic                       s_present_a,
    input logic                       s_present_b,
    input logic                       s_present_c,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic signed [OUT_BITS-1:0] m_centroid,
    input logic [OUT_BITS-1:0]        m_spread,
    input logic                       m_no_weight
);
    // stalled word stays
    `WCS_ASSERT_NEXT(a_hold_valid, m_valid && !m_ready, m_valid, "m_valid dropped under stall")
    `WCS_ASSERT_NEXT(a_hold_data, m_valid && !m_ready,
        $stable(m_centroid) && $stable(m_spread) && $stable(m_no_weight),
        "output word changed under stall")
    // zero weight gives zero results
    `WCS_ASSERT_NOW(a_zero_weight, m_valid && m_no_weight,
        m_centroid == 0 && m_spread == 0, "nonzero result with no weight")
    // input backpressure only when a word is waiting at the output
    `WCS_ASSERT_NOW(a_ready_blk, !s_ready, m_valid, "s_ready low with empty output")
endmodule

bind weighted_centroid_with_spread wcs_checker #(
    .POS_BITS    (POS_BITS),
    .CHARGE_BITS (CHARGE_BITS)
) u_wcs_checker (.*);

// ===== test/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Drives three-pad clusters into weighted_centroid_with_spread and checks each
// output word (centroid, spread, no-weight flag) against an in-bench integer
// model or a hand-written answer, under several sender/receiver idle patterns.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import wcs_pkg::*;

    localparam int POS_BITS    = 16;
    localparam int CHARGE_BITS = 20;
    localparam int LATENCY     = 4 * POS_BITS + 8;
    localparam int N_RANDOM    = 480;

    // one cluster as it goes on the wire
    typedef struct packed {
        logic signed [POS_BITS-1:0] pos_a, pos_b, pos_c;
        logic [CHARGE_BITS-1:0]     charge_a, charge_b, charge_c;
        logic                       present_a, present_b, present_c;
    } cluster_t;

    localparam int CL_BITS = $bits(cluster_t);

    // one output word
    typedef struct packed {
        logic signed [OUT_BITS-1:0] centroid;
        logic [OUT_BITS-1:0]        spread;
        logic                       no_weight;
    } moments_t;

    // a directed row: cluster, and optionally a hand-written answer
    typedef struct {
        cluster_t cl;
        bit       typed;
        moments_t ans;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    cluster_t drv = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [OUT_BITS-1:0] m_centroid;
    logic [OUT_BITS-1:0] m_spread;
    logic m_no_weight;

    moments_t pending_moments[$];
    int       n_errors = 0;
    int       send_idle_pct = 0;   // chance per cycle the sender holds off
    int       recv_stall_pct = 0;  // chance per cycle the receiver stalls

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    weighted_centroid_with_spread #(
        .POS_BITS(POS_BITS), .CHARGE_BITS(CHARGE_BITS)
    ) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pos_a(drv.pos_a), .s_pos_b(drv.pos_b), .s_pos_c(drv.pos_c),
        .s_charge_a(drv.charge_a), .s_charge_b(drv.charge_b),
        .s_charge_c(drv.charge_c),
        .s_present_a(drv.present_a), .s_present_b(drv.present_b),
        .s_present_c(drv.present_c),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_centroid(m_centroid), .m_spread(m_spread), .m_no_weight(m_no_weight)
    );

    // floored integer square root of a wide value
    function automatic logic [63:0] floor_root(input logic [127:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if ({64'd0, t} * {64'd0, t} <= v)
                r = t;
        end
        return r;
    endfunction

    // weighted centroid and spread of the present pads
    function automatic moments_t cluster_moments(input cluster_t c);
        moments_t m;
        logic signed [63:0] z[3];
        logic [63:0] q[3];
        logic here[3];
        logic signed [63:0] wsum;
        logic [63:0] total;
        logic signed [63:0] cen;
        logic signed [63:0] d;
        logic [127:0] var_sum;
        logic [127:0] quo;
        logic [63:0] root;
        z = '{64'(c.pos_a), 64'(c.pos_b), 64'(c.pos_c)};
        q = '{64'(c.charge_a), 64'(c.charge_b), 64'(c.charge_c)};
        here = '{c.present_a, c.present_b, c.present_c};
        wsum = 0;
        total = 0;
        for (int i = 0; i < 3; i++)
            if (here[i]) begin
                wsum += z[i] * $signed(q[i]);
                total += q[i];
            end
        m = '0;
        if (total == 0) begin
            m.no_weight = 1'b1;
            return m;
        end
        cen = wsum / $signed(total);   // SV division truncates toward zero
        var_sum = '0;
        for (int i = 0; i < 3; i++)
            if (here[i]) begin
                d = z[i] - cen;
                if (d < 0) d = -d;
                var_sum += 128'(d) * 128'(d) * 128'(q[i]);
            end
        quo = var_sum / 128'(total);
        root = floor_root(quo);
        if (root > 64'(SPREAD_MAX)) root = 64'(SPREAD_MAX);
        if (cen > 64'(CEN_MAX)) cen = 64'(CEN_MAX);
        if (cen < 64'(CEN_MIN)) cen = 64'(CEN_MIN);
        m.centroid = cen[OUT_BITS-1:0];
        m.spread = root[OUT_BITS-1:0];
        return m;
    endfunction

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        n_errors++;
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    endtask

    // present one cluster; valid stays up between back-to-back words
    task automatic send_cluster(input cluster_t c, input moments_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        drv <= c;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_moments.insert(pending_moments.size(), want);
        @(negedge aclk);
    endtask

    function automatic cluster_t random_cluster();
        cluster_t c;
        int shape;
        c = CL_BITS'({$urandom, $urandom, $urandom, $urandom});
        shape = $urandom_range(9);
        // modest charges in four of ten shapes so centroids land between pads; the rest full-range
        if (shape < 4) begin
            c.charge_a = CHARGE_BITS'($urandom_range(4095));
            c.charge_b = CHARGE_BITS'($urandom_range(4095));
            c.charge_c = CHARGE_BITS'($urandom_range(4095));
        end else if (shape == 4) begin
            c.charge_a = '0;
        end
        // narrow clusters: pads close together
        if (shape >= 6 && shape < 9) begin
            c.pos_b = c.pos_a + $signed(16'($urandom_range(20))) - 16'sd10;
            c.pos_c = c.pos_a + $signed(16'($urandom_range(20))) - 16'sd10;
        end
        return c;
    endfunction

    // receiver: random stalls, compare on every accepted word
    always @(negedge aclk)
        m_ready <= aresetn && ($urandom_range(99) >= recv_stall_pct);

    always @(posedge aclk) begin
        moments_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_moments.size() == 0) begin
                report_mismatch("unexpected word", 0, 0);
            end else begin
                want = pending_moments.pop_front();
                if (m_centroid !== want.centroid)
                    report_mismatch("centroid", m_centroid, want.centroid);
                if (m_spread !== want.spread)
                    report_mismatch("spread", m_spread, want.spread);
                if (m_no_weight !== want.no_weight)
                    report_mismatch("no_weight", m_no_weight, want.no_weight);
            end
        end
    end

    initial begin
        #50ms;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        row_t rows[$];
        row_t r;
        int idle_tab[4][2];
        int wait_cycles;
        idle_tab = '{'{0, 0}, '{63, 0}, '{0, 63}, '{15, 15}};

        // after reset: nothing present -> zero weight
        r.typed = 1; r.cl = '0; r.ans = '{0, 0, 1}; rows.insert(rows.size(), r);
        // present pads, all zero charge
        r.cl = '0; r.cl.present_a = 1; r.cl.present_b = 1; r.cl.present_c = 1;
        r.cl.pos_a = 16'sh7fff; r.cl.pos_b = 16'sh8000; r.ans = '{0, 0, 1};
        rows.insert(rows.size(), r);
        // absent pads carry full charge and must be ignored
        r.cl = '0; r.cl.charge_a = '1; r.cl.charge_b = '1; r.cl.charge_c = '1;
        r.cl.pos_a = 16'sh7fff; r.ans = '{0, 0, 1}; rows.insert(rows.size(), r);
        // single pad at each extreme
        r.cl = '0; r.cl.present_a = 1; r.cl.charge_a = '1; r.cl.pos_a = 16'sh7fff;
        r.ans = '{16'sh7fff, 0, 0}; rows.insert(rows.size(), r);
        r.cl = '0; r.cl.present_b = 1; r.cl.charge_b = 1; r.cl.pos_b = 16'sh8000;
        r.ans = '{16'sh8000, 0, 0}; rows.insert(rows.size(), r);
        // two equal pads at opposite extremes: mean -0.5 -> 0, spread 32767
        r.cl = '0; r.cl.present_a = 1; r.cl.present_c = 1;
        r.cl.charge_a = '1; r.cl.charge_c = '1;
        r.cl.pos_a = 16'sh7fff; r.cl.pos_c = 16'sh8000; r.ans = '{0, 32767, 0};
        rows.insert(rows.size(), r);
        // remaining rows from the predictor
        r.typed = 0;
        r.cl = '0; r.cl.present_a = 1; r.cl.present_b = 1; r.cl.charge_a = 3;
        r.cl.charge_b = 1; r.cl.pos_a = -16'sd7; r.cl.pos_b = 16'sd0;
        rows.insert(rows.size(), r);
        r.cl = {{3{16'sh8000}}, {3{20'hfffff}}, 3'b111}; rows.insert(rows.size(), r);
        r.cl = {16'sh7fff, 16'sh8000, 16'sh0000, 20'h1, 20'hfffff, 20'h1, 3'b111};
        rows.insert(rows.size(), r);
        r.cl = {16'sh8000, 16'sh7fff, 16'sh7fff, 20'hfffff, 20'h1, 20'h80000, 3'b111};
        rows.insert(rows.size(), r);
        r.cl = {16'sh5555, 16'shaaaa, 16'sh0f0f, 20'haaaaa, 20'h55555, 20'h0, 3'b101};
        rows.insert(rows.size(), r);
        r.cl = {16'shaaaa, 16'sh5555, 16'shf0f0, 20'h55555, 20'haaaaa, 20'hfffff, 3'b011};
        rows.insert(rows.size(), r);

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i])
            send_cluster(rows[i].cl,
                         rows[i].typed ? rows[i].ans : cluster_moments(rows[i].cl));

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_tab[ph][0];
            recv_stall_pct = idle_tab[ph][1];
            for (int k = 0; k < N_RANDOM / 4; k++) begin
                cluster_t c;
                c = random_cluster();
                send_cluster(c, cluster_moments(c));
                // hold off once per phase until the pipe drains
                if (k == 40) begin
                    s_valid <= 1'b0;
                    while (pending_moments.size() != 0) @(negedge aclk);
                end
            end
        end

        s_valid <= 1'b0;
        recv_stall_pct = 0;
        while (pending_moments.size() != 0) @(negedge aclk);
        wait_cycles = 2 * LATENCY;
        repeat (wait_cycles) @(posedge aclk);

        if (n_errors == 0 && pending_moments.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/wcs_pkg.sv
hw/rtl/wcs_div_cell.sv
hw/rtl/wcs_sqrt_cell.sv
hw/rtl/weighted_centroid_with_spread.sv
hw/rtl/wcs_checker.sv
test/testbench.sv
